>>> rtl/rib_pkg.sv
// Shared types, constants and helper functions of the ramp interpolator.
package rib_pkg;

   // Field and datapath widths
   localparam int LEN_W     = 31;
   localparam int FRAC_W    = 16;
   localparam int DIR_W     = 16;
   localparam int VAL_W     = 32;
   localparam int FLAG_W    = 8;
   localparam int TD_W      = 16;
   localparam int POS_W     = 34;
   localparam int EXT_W     = 36;
   localparam int STEP_W    = 24;
   localparam int DIFF_W    = 33;
   localparam int PROD_W    = DIFF_W + POS_W;
   localparam int DIGIT_W   = 17;
   localparam int MUL_W     = DIFF_W + DIGIT_W;
   localparam int REM_W     = 32;
   localparam int QUOT_W    = 35;
   localparam int CNT_W     = $clog2(PROD_W);
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_LENGTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DIRECTION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_LOW_END   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_HIGH_END  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MODE_FLAGS  = 3'd5;

   // Bit positions in end_mode_flags
   localparam int FLAG_LOW_STOP    = 0;
   localparam int FLAG_LOW_BOUNCE  = 1;
   localparam int FLAG_LOW_WRAP    = 2;
   localparam int FLAG_LOW_REMOVE  = 3;
   localparam int FLAG_HIGH_STOP   = 4;
   localparam int FLAG_HIGH_BOUNCE = 5;
   localparam int FLAG_HIGH_WRAP   = 6;
   localparam int FLAG_HIGH_REMOVE = 7;

   // Reset values of the registers
   localparam logic [LEN_W-1:0]         RST_RAMP_LENGTH     = 31'd65536;
   localparam logic [FRAC_W-1:0]        RST_START_POSITION  = 16'd0;
   localparam logic signed [DIR_W-1:0]  RST_START_DIRECTION = 16'sd256;
   localparam logic signed [VAL_W-1:0]  RST_VALUE_LOW_END   = 32'sd0;
   localparam logic signed [VAL_W-1:0]  RST_VALUE_HIGH_END  = 32'sd65536;
   localparam logic [FLAG_W-1:0]        RST_END_MODE_FLAGS  = 8'd0;

   // Saturation limits
   localparam logic signed [EXT_W-1:0] POS_MAX_EXT = 36'sd8589934591;
   localparam logic signed [EXT_W-1:0] POS_MIN_EXT = -36'sd8589934592;
   localparam logic signed [EXT_W-1:0] VAL_MAX_EXT = 36'sd2147483647;
   localparam logic signed [EXT_W-1:0] VAL_MIN_EXT = -36'sd2147483648;
   localparam logic signed [DIR_W-1:0] DIR_MIN     = 16'sh8000;
   localparam logic signed [DIR_W-1:0] DIR_MAX     = 16'sh7fff;
   localparam logic [QUOT_W-1:0]       Q_CAP       = 35'h4_0000_0000;

   typedef struct packed {
      logic [LEN_W-1:0]        ramp_length;
      logic [FRAC_W-1:0]       start_position;
      logic signed [DIR_W-1:0] start_direction;
      logic signed [VAL_W-1:0] value_low_end;
      logic signed [VAL_W-1:0] value_high_end;
      logic [FLAG_W-1:0]       end_mode_flags;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DIFF_W-1:0]  a;
      logic [POS_W-1:0]   b;
      logic [LEN_W-1:0]   len;
   } md_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [QUOT_W-1:0]  quot;
   } md_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_ADD,
      ST_RULE,
      ST_MUL,
      ST_WAIT,
      ST_WRITE
   } seq_state_type;

   typedef enum logic [2:0] {
      MD_IDLE,
      MD_MUL_HI,
      MD_MUL_LO,
      MD_DIV,
      MD_DONE
   } md_state_type;

   typedef enum logic [2:0] {
      RULE_LOW_STOP,
      RULE_LOW_BOUNCE,
      RULE_LOW_WRAP,
      RULE_HIGH_STOP,
      RULE_HIGH_BOUNCE,
      RULE_HIGH_WRAP
   } rule_type;

   // Saturate a widened position back to the position range
   function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [EXT_W-1:0] v);
      logic signed [EXT_W-1:0] c;
      c = v;
      if (v > POS_MAX_EXT) begin
         c = POS_MAX_EXT;
      end else if (v < POS_MIN_EXT) begin
         c = POS_MIN_EXT;
      end
      return c[POS_W-1:0];
   endfunction

   // Reverse the direction; the most negative rate turns into the most positive
   function automatic logic signed [DIR_W-1:0] negate_dir(input logic signed [DIR_W-1:0] d);
      logic signed [DIR_W-1:0] n;
      n = (d == DIR_MIN) ? DIR_MAX : -d;
      return n;
   endfunction

endpackage

>>> rtl/rib_if.sv
// Request and response channel interfaces of the ramp interpolator.
interface rib_req_if;
   import rib_pkg::*;
   logic            valid;
   logic            ready;
   logic            operation;
   logic [TD_W-1:0] time_delta;

   modport source (output valid, output operation, output time_delta, input ready);
   modport sink   (input valid, input operation, input time_delta, output ready);
endinterface

interface rib_rsp_if;
   import rib_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] ramp_value;
   logic                    removed;

   modport source (output valid, output ramp_value, output removed, input ready);
   modport sink   (input valid, input ramp_value, input removed, output ready);
endinterface

>>> rtl/rib_csr.sv
// Configuration register file of the ramp interpolator.
module rib_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [rib_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rib_pkg::CSR_DAT_W-1:0]   csr_write_data,
   output rib_pkg::cfg_type                cfg
);
   import rib_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write and update one field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RAMP_LENGTH:     cfg_in.ramp_length     = csr_write_data[LEN_W-1:0];
            CSR_START_POSITION:  cfg_in.start_position  = csr_write_data[FRAC_W-1:0];
            CSR_START_DIRECTION: cfg_in.start_direction = csr_write_data[DIR_W-1:0];
            CSR_VALUE_LOW_END:   cfg_in.value_low_end   = csr_write_data[VAL_W-1:0];
            CSR_VALUE_HIGH_END:  cfg_in.value_high_end  = csr_write_data[VAL_W-1:0];
            CSR_END_MODE_FLAGS:  cfg_in.end_mode_flags  = csr_write_data[FLAG_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_length     <= RST_RAMP_LENGTH;
         cfg_ff.start_position  <= RST_START_POSITION;
         cfg_ff.start_direction <= RST_START_DIRECTION;
         cfg_ff.value_low_end   <= RST_VALUE_LOW_END;
         cfg_ff.value_high_end  <= RST_VALUE_HIGH_END;
         cfg_ff.end_mode_flags  <= RST_END_MODE_FLAGS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/rib_mul_div.sv
// Shared multiply and restoring divide unit: |diff| * |position| / length.
module rib_mul_div (
   input  logic                   clock,
   input  logic                   reset,
   input  rib_pkg::md_req_type    md_req,
   output rib_pkg::md_status_type md_status
);
   import rib_pkg::*;

   md_state_type state_ff, state_in;

   logic [DIFF_W-1:0]  a_ff, a_in;
   logic [POS_W-1:0]   b_ff, b_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic               sat_ff, sat_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [DIGIT_W-1:0] mul_digit;
   logic [MUL_W-1:0]   mul_w;
   logic [REM_W:0]     rem_shift;
   logic [REM_W:0]     rem_sub;
   logic               rem_ge;
   logic [QUOT_W:0]    quot_shift;

   // One multiplier, fed the high digit of b first, then the low digit
   assign mul_digit  = (state_ff == MD_MUL_HI) ? b_ff[POS_W-1:DIGIT_W] : b_ff[DIGIT_W-1:0];
   assign mul_w      = a_ff * mul_digit;

   // One restoring divide step per cycle
   assign rem_shift  = {rem_ff, prod_ff[PROD_W-1]};
   assign rem_ge     = rem_shift >= {{(REM_W+1-LEN_W){1'b0}}, len_ff};
   assign rem_sub    = rem_shift - {{(REM_W+1-LEN_W){1'b0}}, len_ff};
   assign quot_shift = {quot_ff, rem_ge};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         MD_IDLE:   if (md_req.start) begin
            state_in = MD_MUL_HI;
         end
         MD_MUL_HI: state_in = MD_MUL_LO;
         MD_MUL_LO: state_in = MD_DIV;
         MD_DIV:    if (count_ff == '0) begin
            state_in = MD_DONE;
         end
         MD_DONE:   state_in = MD_IDLE;
         default:   state_in = MD_IDLE;
      endcase
   end

   // Datapath
   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      len_in   = len_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      sat_in   = sat_ff;
      count_in = count_ff;
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               a_in   = md_req.a;
               b_in   = md_req.b;
               len_in = md_req.len;
            end
         end
         MD_MUL_HI: begin
            prod_in = PROD_W'(mul_w);
         end
         MD_MUL_LO: begin
            prod_in  = (prod_ff << DIGIT_W) + PROD_W'(mul_w);
            rem_in   = '0;
            quot_in  = '0;
            sat_in   = 1'b0;
            count_in = CNT_W'(PROD_W - 1);
         end
         MD_DIV: begin
            prod_in  = prod_ff << 1;
            rem_in   = rem_ge ? rem_sub[REM_W-1:0] : rem_shift[REM_W-1:0];
            count_in = count_ff - 1'b1;
            // Freeze the quotient at the cap once it runs past it
            if (!sat_ff) begin
               if (quot_shift > {1'b0, Q_CAP}) begin
                  quot_in = Q_CAP;
                  sat_in  = 1'b1;
               end else begin
                  quot_in = quot_shift[QUOT_W-1:0];
               end
            end
         end
         MD_DONE: begin
            quot_in = quot_ff;
         end
         default: begin
            quot_in = quot_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      len_ff   <= len_in;
      prod_ff  <= prod_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      sat_ff   <= sat_in;
      count_ff <= count_in;
   end

   // Status
   always_comb begin
      md_status.busy = (state_ff != MD_IDLE);
      md_status.done = (state_ff == MD_DONE);
      md_status.quot = quot_ff;
   end

endmodule

>>> rtl/ramp_interpolator_bounce_wrap.sv
// Top level of the ramp interpolator: tick sequencer, end rules and result register.
//
//   channel    dir   handshake       payload
//   req_chan   in    valid/ready     operation, time_delta
//   rsp_chan   out   valid/ready     ramp_value, removed
//   csr_*      in    write enable    csr_index, csr_write_data
//
// A restart transfer, or a tick that is dropped because the ramp has ended or
// stands still, leaves the block idle and ready. A producing tick runs through
// step multiply, position add, six end rules at one a cycle, then the shared unit
// (high and low multiply and 67 divide steps) and the result write.
// Reset is synchronous and restores the position, direction and registers.
// A waiting result does not block the next transfer; a finished tick holds
// in its write state until the result register is free.
module ramp_interpolator_bounce_wrap (
   input  logic                          clock,
   input  logic                          reset,
   rib_req_if.sink                       req_chan,
   rib_rsp_if.source                     rsp_chan,
   input  logic                          csr_write_enable,
   input  logic [rib_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rib_pkg::CSR_DAT_W-1:0] csr_write_data
);
   import rib_pkg::*;

   cfg_type       cfg;
   md_req_type    md_req;
   md_status_type md_status;

   seq_state_type state_ff, state_in;
   rule_type      rule_ff, rule_in;

   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic signed [DIR_W-1:0]  dir_ff, dir_in;
   logic                     ended_ff, ended_in;
   logic [TD_W-1:0]          td_ff, td_in;
   logic signed [STEP_W-1:0] step_ff, step_in;
   logic                     neg_ff, neg_in;
   logic                     remove_ff, remove_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [VAL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                     rsp_removed_ff, rsp_removed_in;

   logic                     req_xfer;
   logic                     rsp_free;
   logic signed [EXT_W-1:0]  pos_ext;
   logic signed [EXT_W-1:0]  len_ext;
   logic                     at_low;
   logic                     at_high;
   logic signed [DIFF_W-1:0] diff_w;
   logic signed [DIFF_W-1:0] step_prod;
   logic signed [EXT_W-1:0]  quot_ext;
   logic signed [EXT_W-1:0]  value_sum;
   logic [FLAG_W-1:0]        flags;

   rib_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rib_mul_div u_mul_div (
      .clock     (clock),
      .reset     (reset),
      .md_req    (md_req),
      .md_status (md_status)
   );

   assign req_xfer  = req_chan.valid && req_chan.ready;
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;
   assign flags     = cfg.end_mode_flags;
   assign pos_ext   = {{(EXT_W-POS_W){pos_ff[POS_W-1]}}, pos_ff};
   assign len_ext   = {{(EXT_W-LEN_W){1'b0}}, cfg.ramp_length};
   assign at_low    = pos_ff[POS_W-1] || (pos_ff == '0);
   assign at_high   = pos_ext >= len_ext;
   assign diff_w    = {cfg.value_high_end[VAL_W-1], cfg.value_high_end}
                    - {cfg.value_low_end[VAL_W-1], cfg.value_low_end};
   assign step_prod = $signed({1'b0, td_ff}) * dir_ff;
   assign quot_ext  = $signed({1'b0, md_status.quot});
   assign value_sum = {{(EXT_W-VAL_W){cfg.value_low_end[VAL_W-1]}}, cfg.value_low_end}
                    + (neg_ff ? -quot_ext : quot_ext);

   // Operands for the shared unit: magnitudes of the value span and the position
   always_comb begin
      md_req.start = (state_ff == ST_MUL);
      md_req.a     = diff_w[DIFF_W-1] ? DIFF_W'(-diff_w) : DIFF_W'(diff_w);
      md_req.b     = pos_ff[POS_W-1] ? POS_W'(-pos_ff) : POS_W'(pos_ff);
      md_req.len   = cfg.ramp_length;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && !req_chan.operation && !ended_ff && (dir_ff != '0)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP:  state_in = ST_ADD;
         ST_ADD:   state_in = ST_RULE;
         ST_RULE: begin
            if (rule_ff == RULE_HIGH_WRAP) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (md_status.done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
   end

   // Ramp state and end rules
   always_comb begin
      pos_in    = pos_ff;
      dir_in    = dir_ff;
      ended_in  = ended_ff;
      td_in     = td_ff;
      step_in   = step_ff;
      rule_in   = rule_ff;
      neg_in    = neg_ff;
      remove_in = remove_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.operation) begin
                  pos_in   = POS_W'(cfg.start_position);
                  dir_in   = cfg.start_direction;
                  ended_in = 1'b0;
               end else begin
                  td_in = req_chan.time_delta;
               end
            end
         end
         ST_STEP: begin
            // Arithmetic shift floors the Q8.8 product to Q.16 time
            step_in = step_prod[STEP_W+7:8];
         end
         ST_ADD: begin
            pos_in  = clamp_pos(pos_ext + {{(EXT_W-STEP_W){step_ff[STEP_W-1]}}, step_ff});
            rule_in = RULE_LOW_STOP;
         end
         ST_RULE: begin
            rule_in = rule_type'(rule_ff + 3'd1);
            unique case (rule_ff)
               RULE_LOW_STOP: begin
                  if (at_low && flags[FLAG_LOW_STOP]) begin
                     dir_in = '0;
                     pos_in = '0;
                  end
               end
               RULE_LOW_BOUNCE: begin
                  if (at_low && flags[FLAG_LOW_BOUNCE]) begin
                     dir_in = negate_dir(dir_ff);
                     pos_in = clamp_pos(-pos_ext);
                  end
               end
               RULE_LOW_WRAP: begin
                  if (at_low && flags[FLAG_LOW_WRAP]) begin
                     pos_in = clamp_pos(len_ext + pos_ext);
                  end
               end
               RULE_HIGH_STOP: begin
                  if (at_high && flags[FLAG_HIGH_STOP]) begin
                     dir_in = '0;
                     pos_in = POS_W'(cfg.ramp_length);
                  end
               end
               RULE_HIGH_BOUNCE: begin
                  if (at_high && flags[FLAG_HIGH_BOUNCE]) begin
                     dir_in = negate_dir(dir_ff);
                     pos_in = clamp_pos((len_ext <<< 1) - pos_ext);
                  end
               end
               RULE_HIGH_WRAP: begin
                  rule_in = RULE_LOW_STOP;
                  if (at_high && flags[FLAG_HIGH_WRAP]) begin
                     pos_in = clamp_pos(pos_ext - len_ext);
                  end
               end
               default: begin
                  rule_in = RULE_LOW_STOP;
               end
            endcase
         end
         ST_MUL: begin
            // Position is final here: latch the result sign and the remove match
            neg_in    = diff_w[DIFF_W-1] != pos_ff[POS_W-1];
            remove_in = (at_low && flags[FLAG_LOW_REMOVE])
                     || (at_high && flags[FLAG_HIGH_REMOVE]);
         end
         ST_WAIT: begin
            neg_in = neg_ff;
         end
         ST_WRITE: begin
            if (rsp_free && remove_ff) begin
               ended_in = 1'b1;
            end
         end
         default: begin
            rule_in = RULE_LOW_STOP;
         end
      endcase
   end

   // Result register: load on write, drop on transfer
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in   = rsp_value_ff;
      rsp_removed_in = rsp_removed_ff;
      if ((state_ff == ST_WRITE) && rsp_free) begin
         rsp_valid_in   = 1'b1;
         rsp_removed_in = remove_ff;
         if (value_sum > VAL_MAX_EXT) begin
            rsp_value_in = VAL_MAX_EXT[VAL_W-1:0];
         end else if (value_sum < VAL_MIN_EXT) begin
            rsp_value_in = VAL_MIN_EXT[VAL_W-1:0];
         end else begin
            rsp_value_in = value_sum[VAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rule_ff      <= RULE_LOW_STOP;
         pos_ff       <= '0;
         dir_ff       <= RST_START_DIRECTION;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rule_ff      <= rule_in;
         pos_ff       <= pos_in;
         dir_ff       <= dir_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      td_ff          <= td_in;
      step_ff        <= step_in;
      neg_ff         <= neg_in;
      remove_ff      <= remove_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_removed_ff <= rsp_removed_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ramp_value = rsp_value_ff;
   assign rsp_chan.removed    = rsp_removed_ff;

   // A restart always revives the ramp
   a_restart_clears_end: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_chan.operation |=> !ended_ff)
      else $error("restart did not clear the ended flag");

   // No new transfer while the shared unit is working
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      md_status.busy |-> !req_chan.ready)
      else $error("request accepted while the shared unit is busy");

   // A tick only starts on a live, moving ramp
   a_step_live: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> !ended_ff && (dir_ff != '0))
      else $error("tick started on an ended or stopped ramp");

   // A result is written only after the shared unit finished
   a_write_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_WRITE) |-> $past(md_status.done))
      else $error("result written without a finished division");

endmodule

>>> test/ramp_interpolator_bounce_wrap_tb.sv
// Self-checking testbench of the ramp interpolator: directed end-rule cases, then random ramps.
`timescale 1ns / 1ps

module ramp_interpolator_bounce_wrap_tb;
   import rib_pkg::*;

   localparam bit OP_TICK    = 1'b0;
   localparam bit OP_RESTART = 1'b1;

   localparam int RANDOM_ITEMS  = 1425;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int REPORT_LIMIT  = 10;

   localparam longint POSITION_MAX = 64'sd8589934591;
   localparam longint POSITION_MIN = -64'sd8589934592;
   localparam longint VALUE_MAX    = 64'sd2147483647;
   localparam longint VALUE_MIN    = -64'sd2147483648;
   localparam longint QUOT_LIMIT   = 64'sd17179869184;

   typedef struct {
      logic signed [VAL_W-1:0] value;
      logic                    removed;
   } ramp_result_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_write_data;

   rib_req_if req_chan ();
   rib_rsp_if rsp_chan ();

   ramp_interpolator_bounce_wrap dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Register copies held by the predictor
   logic [LEN_W-1:0]        cfg_length;
   logic [FRAC_W-1:0]       cfg_start_pos;
   logic signed [DIR_W-1:0] cfg_start_rate;
   logic signed [VAL_W-1:0] cfg_low_value;
   logic signed [VAL_W-1:0] cfg_high_value;
   logic [FLAG_W-1:0]       cfg_flags;

   // Ramp state held by the predictor
   longint                  ramp_pos;
   logic signed [DIR_W-1:0] ramp_rate;
   bit                      ramp_ended;

   ramp_result_type awaited_ramp_results[$];
   ramp_result_type oldest_awaited;

   int  error_count;
   int  cycle_count;
   int  items_accepted;
   int  items_effective;
   int  restarts_accepted;
   int  results_checked;
   int  removals_seen;
   int  burst_left;
   int  rsp_hold_cycles;
   bit  gaps_on;
   bit  rsp_stalls_on;

   // Clock: 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_ramp_results.size());
         $display("ramp_interpolator_bounce_wrap_tb: errors");
         $finish;
      end
   end

   // Result side: hold ready in segments of random length, open or stalling
   always @(posedge clock) begin
      if (rsp_hold_cycles == 0) begin
         rsp_hold_cycles <= $urandom_range(1, 12);
         if (!rsp_stalls_on) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 2) != 0);
         end
      end else begin
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end
   end

   function automatic logic [CSR_DAT_W-1:0] end_flag(input int bit_pos);
      return 32'd1 << bit_pos;
   endfunction

   function automatic longint clamp_position(input longint p);
      if (p > POSITION_MAX) return POSITION_MAX;
      if (p < POSITION_MIN) return POSITION_MIN;
      return p;
   endfunction

   function automatic logic signed [DIR_W-1:0] reverse_rate(input logic signed [DIR_W-1:0] r);
      if (r == 16'sh8000) return 16'sh7fff;
      return -r;
   endfunction

   // Linear interpolation between the end values, quotient capped, sum saturated
   function automatic logic signed [VAL_W-1:0] interpolate_value(input longint pos);
      longint       low_l;
      longint       high_l;
      longint       diff;
      longint       q;
      longint       sum;
      logic [127:0] mag_diff;
      logic [127:0] mag_pos;
      logic [127:0] product;
      logic [127:0] divisor;
      logic [127:0] quotient;
      bit           negative;
      low_l    = 64'(cfg_low_value);
      high_l   = 64'(cfg_high_value);
      diff     = high_l - low_l;
      negative = (diff < 0) != (pos < 0);
      mag_diff = 128'((diff < 0) ? -diff : diff);
      mag_pos  = 128'((pos < 0) ? -pos : pos);
      product  = mag_diff * mag_pos;
      divisor  = {97'd0, cfg_length};
      if (divisor == 0) begin
         quotient = 128'(QUOT_LIMIT);
      end else begin
         quotient = product / divisor;
      end
      if (quotient > 128'(QUOT_LIMIT)) begin
         quotient = 128'(QUOT_LIMIT);
      end
      q   = quotient[63:0];
      sum = low_l + (negative ? -q : q);
      if (sum > VALUE_MAX) sum = VALUE_MAX;
      if (sum < VALUE_MIN) sum = VALUE_MIN;
      return sum[VAL_W-1:0];
   endfunction

   // Advance the predicted ramp by one accepted item and queue the result of a producing tick
   function automatic void predict_ramp(input bit op, input logic [TD_W-1:0] td);
      longint          len;
      longint          delta_l;
      longint          rate_l;
      ramp_result_type res;
      len = {33'd0, cfg_length};
      if (op == OP_RESTART) begin
         ramp_pos   = {48'd0, cfg_start_pos};
         ramp_rate  = cfg_start_rate;
         ramp_ended = 1'b0;
         restarts_accepted++;
         items_effective++;
         return;
      end
      if (ramp_ended || ramp_rate == 0) begin
         return;
      end
      items_effective++;
      delta_l  = {48'd0, td};
      rate_l   = 64'(ramp_rate);
      ramp_pos = clamp_position(ramp_pos + ((delta_l * rate_l) >>> 8));

      // Low end rules, then high end rules, each on the position left by the last
      if (ramp_pos <= 0 && cfg_flags[FLAG_LOW_STOP]) begin
         ramp_rate = '0;
         ramp_pos  = 0;
      end
      if (ramp_pos <= 0 && cfg_flags[FLAG_LOW_BOUNCE]) begin
         ramp_rate = reverse_rate(ramp_rate);
         ramp_pos  = clamp_position(-ramp_pos);
      end
      if (ramp_pos <= 0 && cfg_flags[FLAG_LOW_WRAP]) begin
         ramp_pos = clamp_position(len + ramp_pos);
      end
      if (ramp_pos >= len && cfg_flags[FLAG_HIGH_STOP]) begin
         ramp_rate = '0;
         ramp_pos  = len;
      end
      if (ramp_pos >= len && cfg_flags[FLAG_HIGH_BOUNCE]) begin
         ramp_rate = reverse_rate(ramp_rate);
         ramp_pos  = clamp_position(2 * len - ramp_pos);
      end
      if (ramp_pos >= len && cfg_flags[FLAG_HIGH_WRAP]) begin
         ramp_pos = clamp_position(ramp_pos - len);
      end

      res.value   = interpolate_value(ramp_pos);
      res.removed = (ramp_pos <= 0 && cfg_flags[FLAG_LOW_REMOVE]) ||
                    (ramp_pos >= len && cfg_flags[FLAG_HIGH_REMOVE]);
      if (res.removed) begin
         ramp_ended = 1'b1;
      end
      awaited_ramp_results.push_back(res);
   endfunction

   function automatic void note_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("[%0d] %s", cycle_count, msg);
      end
   endfunction

   // Check each result transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         results_checked++;
         if (rsp_chan.removed === 1'b1) begin
            removals_seen++;
         end
         if (awaited_ramp_results.size() == 0) begin
            note_error($sformatf("unexpected result value %0d removed %0b",
                                 rsp_chan.ramp_value, rsp_chan.removed));
         end else begin
            oldest_awaited = awaited_ramp_results.pop_front();
            if (oldest_awaited.value !== rsp_chan.ramp_value ||
                oldest_awaited.removed !== rsp_chan.removed) begin
               note_error($sformatf("result %0d: expected value %0d removed %0b, got %0d %0b",
                                    results_checked, oldest_awaited.value,
                                    oldest_awaited.removed, rsp_chan.ramp_value,
                                    rsp_chan.removed));
            end
         end
      end
   end

   // Write one register and mirror it in the predictor
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_RAMP_LENGTH:     cfg_length     = data[LEN_W-1:0];
         CSR_START_POSITION:  cfg_start_pos  = data[FRAC_W-1:0];
         CSR_START_DIRECTION: cfg_start_rate = data[DIR_W-1:0];
         CSR_VALUE_LOW_END:   cfg_low_value  = data;
         CSR_VALUE_HIGH_END:  cfg_high_value = data;
         CSR_END_MODE_FLAGS:  cfg_flags      = data[FLAG_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Send one item; bursts of random length with random gaps between them when gaps are on
   task automatic send_item(input bit op, input logic [TD_W-1:0] td);
      int gap;
      gap = 0;
      if (gaps_on && burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.operation  <= op;
      req_chan.time_delta <= td;
      do @(posedge clock); while (!req_chan.ready);
      items_accepted++;
      predict_ramp(op, td);
   endtask

   // Drop valid, wait for every predicted result, then let the block go idle
   task automatic settle_block();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (awaited_ramp_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_state();
      gaps_on       = 1'b0;
      rsp_stalls_on = 1'b0;
      send_item(OP_TICK, 16'h0000);
      send_item(OP_TICK, 16'hffff);
      send_item(OP_RESTART, 16'hffff);
      send_item(OP_TICK, 16'h8000);
      settle_block();
   endtask

   task automatic test_low_end_rules();
      // Most negative rate, extreme end values; stop and remove at the low end
      write_reg(CSR_RAMP_LENGTH, 32'd65536);
      write_reg(CSR_START_POSITION, 32'h0000_ffff);
      write_reg(CSR_START_DIRECTION, 32'h0000_8000);
      write_reg(CSR_VALUE_LOW_END, 32'h8000_0000);
      write_reg(CSR_VALUE_HIGH_END, 32'h7fff_ffff);
      write_reg(CSR_END_MODE_FLAGS, end_flag(FLAG_LOW_STOP) | end_flag(FLAG_LOW_REMOVE));
      send_item(OP_RESTART, 16'h0000);
      send_item(OP_TICK, 16'hffff);
      send_item(OP_TICK, 16'd100);
      settle_block();

      // Bounce off the low end with the most negative rate
      write_reg(CSR_END_MODE_FLAGS, end_flag(FLAG_LOW_BOUNCE));
      send_item(OP_RESTART, 16'h0000);
      send_item(OP_TICK, 16'hffff);
      send_item(OP_TICK, 16'hffff);
      settle_block();

      // Wrap at the low end
      write_reg(CSR_START_DIRECTION, 32'h0000_ff00);
      write_reg(CSR_END_MODE_FLAGS, end_flag(FLAG_LOW_WRAP));
      send_item(OP_RESTART, 16'h0000);
      send_item(OP_TICK, 16'hffff);
      send_item(OP_TICK, 16'h0001);
      settle_block();
   endtask

   task automatic test_high_end_rules();
      // Shortest nonzero ramp, fastest rate, end values swapped
      write_reg(CSR_RAMP_LENGTH, 32'd1);
      write_reg(CSR_START_POSITION, 32'd0);
      write_reg(CSR_START_DIRECTION, 32'h0000_7fff);
      write_reg(CSR_VALUE_LOW_END, 32'h7fff_ffff);
      write_reg(CSR_VALUE_HIGH_END, 32'h8000_0000);
      write_reg(CSR_END_MODE_FLAGS, end_flag(FLAG_HIGH_STOP) | end_flag(FLAG_HIGH_REMOVE));
      send_item(OP_RESTART, 16'h0000);
      send_item(OP_TICK, 16'hffff);
      send_item(OP_TICK, 16'h0001);
      settle_block();

      write_reg(CSR_END_MODE_FLAGS, end_flag(FLAG_HIGH_BOUNCE));
      send_item(OP_RESTART, 16'h0000);
      send_item(OP_TICK, 16'hffff);
      settle_block();

      write_reg(CSR_END_MODE_FLAGS, end_flag(FLAG_HIGH_WRAP) | end_flag(FLAG_LOW_BOUNCE));
      send_item(OP_RESTART, 16'h0000);
      send_item(OP_TICK, 16'h0003);
      settle_block();
   endtask

   task automatic test_stand_still_and_length_edges();
      // Zero rate: the tick is dropped
      write_reg(CSR_END_MODE_FLAGS, 32'd0);
      write_reg(CSR_START_DIRECTION, 32'd0);
      send_item(OP_RESTART, 16'h0000);
      send_item(OP_TICK, 16'd1000);
      settle_block();

      // Zero ramp length saturates the value, then the longest ramp
      write_reg(CSR_RAMP_LENGTH, 32'd0);
      write_reg(CSR_START_DIRECTION, 32'd256);
      write_reg(CSR_START_POSITION, 32'h0000_8000);
      send_item(OP_RESTART, 16'h0000);
      send_item(OP_TICK, 16'd200);
      settle_block();
      write_reg(CSR_RAMP_LENGTH, 32'h7fff_ffff);
      send_item(OP_TICK, 16'hffff);
      settle_block();
   endtask

   task automatic test_random_ramps();
      int                   accepted_start;
      int                   ticks;
      logic [CSR_DAT_W-1:0] data;
      logic [TD_W-1:0]      delta;
      accepted_start = items_accepted;
      while (items_accepted - accepted_start < RANDOM_ITEMS) begin
         settle_block();

         // Pick a new setting, extremes included
         case ($urandom_range(0, 5))
            0: data = 32'd1;
            1: data = $urandom_range(2, 4096);
            2: data = $urandom_range(32'h0000_4000, 32'h0010_0000);
            3: data = 32'h7fff_ffff;
            4: data = $urandom;
            default: data = 32'd65536;
         endcase
         if (data[LEN_W-1:0] == 0) begin
            data = 32'd1;
         end
         write_reg(CSR_RAMP_LENGTH, data);
         case ($urandom_range(0, 3))
            0: data = 32'd0;
            1: data = 32'h0000_ffff;
            default: data = $urandom;
         endcase
         write_reg(CSR_START_POSITION, data);
         case ($urandom_range(0, 7))
            0: data = 32'h0000_8000;
            1: data = 32'h0000_7fff;
            2: data = 32'd0;
            3: data = $urandom_range(0, 512) - 256;
            default: data = $urandom;
         endcase
         write_reg(CSR_START_DIRECTION, data);
         case ($urandom_range(0, 3))
            0: data = 32'h8000_0000;
            1: data = 32'h7fff_ffff;
            default: data = $urandom;
         endcase
         write_reg(CSR_VALUE_LOW_END, data);
         case ($urandom_range(0, 3))
            0: data = 32'h8000_0000;
            1: data = 32'h7fff_ffff;
            default: data = $urandom;
         endcase
         write_reg(CSR_VALUE_HIGH_END, data);
         data = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
         write_reg(CSR_END_MODE_FLAGS, data);

         gaps_on       = ($urandom_range(0, 4) != 0);
         rsp_stalls_on = ($urandom_range(0, 4) != 0);

         // Well-formed ramps: a restart followed by ticks, with stray restarts
         repeat ($urandom_range(1, 4)) begin
            send_item(OP_RESTART, 16'($urandom));
            ticks = $urandom_range(4, 40);
            repeat (ticks) begin
               case ($urandom_range(0, 9))
                  0: delta = 16'h0000;
                  1: delta = 16'hffff;
                  2, 3: delta = 16'($urandom_range(1, 255));
                  default: delta = 16'($urandom);
               endcase
               if ($urandom_range(0, 29) == 0) begin
                  send_item(OP_RESTART, delta);
               end else begin
                  send_item(OP_TICK, delta);
               end
            end
         end
      end
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_chan.valid      = 1'b0;
      req_chan.operation  = 1'b0;
      req_chan.time_delta = '0;
      rsp_chan.ready      = 1'b0;
      rsp_hold_cycles     = 0;
      error_count       = 0;
      cycle_count       = 0;
      items_accepted    = 0;
      items_effective   = 0;
      restarts_accepted = 0;
      results_checked   = 0;
      removals_seen     = 0;
      burst_left        = 0;
      gaps_on           = 1'b0;
      rsp_stalls_on     = 1'b0;

      // Predictor starts from the reset state
      cfg_length     = RST_RAMP_LENGTH;
      cfg_start_pos  = RST_START_POSITION;
      cfg_start_rate = RST_START_DIRECTION;
      cfg_low_value  = RST_VALUE_LOW_END;
      cfg_high_value = RST_VALUE_HIGH_END;
      cfg_flags      = RST_END_MODE_FLAGS;
      ramp_pos       = 0;
      ramp_rate      = RST_START_DIRECTION;
      ramp_ended     = 1'b0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      test_reset_state();
      test_low_end_rules();
      test_high_end_rules();
      test_stand_still_and_length_edges();
      test_random_ramps();
      settle_block();

      if (awaited_ramp_results.size() != 0) begin
         note_error($sformatf("%0d predicted results never arrived",
                              awaited_ramp_results.size()));
      end

      $display("covered %0d transfers (%0d restarts, %0d took effect), %0d results, %0d removals",
               items_accepted, restarts_accepted, items_effective, results_checked,
               removals_seen);
      $display("end rules, saturation, zero rate and length edges; %0d mismatches in %0d cycles",
               error_count, cycle_count);
      if (error_count == 0) begin
         $display("ramp_interpolator_bounce_wrap_tb: clean");
      end else begin
         $display("ramp_interpolator_bounce_wrap_tb: errors");
      end
      $finish;
   end

endmodule
